/* rtl/core/pi_controller_antiwindup_pwm_macros.svh */
// Assertion macros for the PI controller block.
// Clocked on clk_i, disabled while rst_ni is low; compiled out with NO_ASSERTIONS.
`ifndef PI_CONTROLLER_ANTIWINDUP_PWM_MACROS_SVH
`define PI_CONTROLLER_ANTIWINDUP_PWM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PIAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PIAW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PIAW_ASSERT(lbl, prop, msg)

`define PIAW_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/core/piaw_pkg.sv */
// Shared types, widths and reset values for the PI controller block.
// No dependencies.
`timescale 1ns / 1ps

package piaw_pkg;

  localparam int CodeW    = 12;
  localparam int PctW     = 7;
  localparam int ErrW     = 8;
  localparam int IntegW   = 12;
  localparam int PropW    = 14;
  localparam int IgainW   = 10;
  localparam int LimW     = 10;
  localparam int LevelW   = 7;
  localparam int DutyW    = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 14;

  typedef enum logic [CfgIdxW-1:0] {
    RegPropGain  = 3'd0,
    RegIntegGain = 3'd1,
    RegWindupLim = 3'd2,
    RegAlarmOn   = 3'd3,
    RegAlarmOff  = 3'd4
  } cfg_reg_e;

  localparam logic [PropW-1:0]  PropGainRst  = 14'd140;
  localparam logic [IgainW-1:0] IntegGainRst = 10'd6;
  localparam logic [LimW-1:0]   WindupLimRst = 10'd100;
  localparam logic [LevelW-1:0] AlarmOnRst   = 7'd20;
  localparam logic [LevelW-1:0] AlarmOffRst  = 7'd10;

  typedef struct packed {
    logic [PropW-1:0]  prop_gain;
    logic [IgainW-1:0] integ_gain;
    logic [LimW-1:0]   windup_limit;
    logic [LevelW-1:0] alarm_on_level;
    logic [LevelW-1:0] alarm_off_level;
  } cfg_t;

  typedef struct packed {
    logic signed [ErrW-1:0]   err;
    logic signed [IntegW-1:0] integ;
    logic                     alarm;
  } front_res_t;

endpackage

/* rtl/core/pi_controller_antiwindup_pwm.sv */
// PI controller with clamped integrator and PWM duty output; top level.
// Pipeline: three front and three back stages, each one registered.
// Throughput: one transfer per cycle while the output is not stalled; the integrator loop closes in a single stage.
// Each stage holds while the next is full and stalled, so input stalls only when all are full.
// Reset: configuration to defaults, integrator zero, alarm off, pipeline empty.
// Depends on piaw_pkg, piaw_cfg, piaw_front, piaw_back and the macros header.
`timescale 1ns / 1ps
`include "pi_controller_antiwindup_pwm_macros.svh"

module pi_controller_antiwindup_pwm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [piaw_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [piaw_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [piaw_pkg::CodeW-1:0]       target_code_i,
  input  logic [piaw_pkg::CodeW-1:0]       measured_code_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [piaw_pkg::DutyW-1:0]       duty_o,
  output logic [piaw_pkg::PctW-1:0]        drive_pct_o,
  output logic signed [piaw_pkg::ErrW-1:0] error_pct_o,
  output logic                             alarm_o
);

  piaw_pkg::cfg_t       cfg;
  piaw_pkg::front_res_t front_res;
  logic                 front_rdy, front_vld, back_rdy;

  piaw_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  piaw_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .vld_i           (in_valid_i),
    .rdy_o           (front_rdy),
    .target_code_i   (target_code_i),
    .measured_code_i (measured_code_i),
    .vld_o           (front_vld),
    .rdy_i           (back_rdy),
    .res_o           (front_res)
  );

  piaw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .vld_i       (front_vld),
    .rdy_o       (back_rdy),
    .res_i       (front_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duty_o      (duty_o),
    .drive_pct_o (drive_pct_o),
    .error_pct_o (error_pct_o),
    .alarm_o     (alarm_o)
  );

  assign in_stall_o = !front_rdy;

  `PIAW_ASSERT(a_stall_only_when_full, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled while output free")
  `PIAW_ASSERT(a_integ_in_limit, front_vld |-> ((front_res.integ <= $signed({2'd0, cfg.windup_limit})) && (front_res.integ >= -$signed({2'd0, cfg.windup_limit}))), "integrator outside windup limit")
  `PIAW_NEVER(a_alarm_off_small_err, front_vld && front_res.alarm && (front_res.err <= $signed({1'b0, cfg.alarm_off_level})) && (front_res.err >= -$signed({1'b0, cfg.alarm_off_level})), "alarm on below off level")
  `PIAW_ASSERT(a_duty_full_scale, out_valid_o |-> ((drive_pct_o <= 7'd100) && ((drive_pct_o == 7'd100) == (duty_o == 10'd1023))), "duty and drive disagree")

endmodule

/* rtl/core/piaw_cfg.sv */
// Configuration register file of the PI controller block.
// Depends on piaw_pkg.
`timescale 1ns / 1ps

module piaw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [piaw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [piaw_pkg::CfgDataW-1:0]  cfg_data_i,
  output piaw_pkg::cfg_t                 cfg_o
);

  piaw_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= piaw_pkg::PropGainRst;
      cfg_q.integ_gain      <= piaw_pkg::IntegGainRst;
      cfg_q.windup_limit    <= piaw_pkg::WindupLimRst;
      cfg_q.alarm_on_level  <= piaw_pkg::AlarmOnRst;
      cfg_q.alarm_off_level <= piaw_pkg::AlarmOffRst;
    end else if (cfg_we_i) begin
      unique case (piaw_pkg::cfg_reg_e'(cfg_idx_i))
        piaw_pkg::RegPropGain:  cfg_q.prop_gain       <= cfg_data_i[piaw_pkg::PropW-1:0];
        piaw_pkg::RegIntegGain: cfg_q.integ_gain      <= cfg_data_i[piaw_pkg::IgainW-1:0];
        piaw_pkg::RegWindupLim: cfg_q.windup_limit    <= cfg_data_i[piaw_pkg::LimW-1:0];
        piaw_pkg::RegAlarmOn:   cfg_q.alarm_on_level  <= cfg_data_i[piaw_pkg::LevelW-1:0];
        piaw_pkg::RegAlarmOff:  cfg_q.alarm_off_level <= cfg_data_i[piaw_pkg::LevelW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/piaw_front.sv */
// Front pipeline: input register, code-to-percent scaling, error, clamped
// integrator and alarm hysteresis. Depends on piaw_pkg.
`timescale 1ns / 1ps

module piaw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  piaw_pkg::cfg_t                cfg_i,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic [piaw_pkg::CodeW-1:0]    target_code_i,
  input  logic [piaw_pkg::CodeW-1:0]    measured_code_i,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output piaw_pkg::front_res_t          res_o
);

  // floor(code*100/4095): x/4096 is low by at most one, fix with the remainder
  function automatic logic [piaw_pkg::PctW-1:0] code_to_pct(
    input logic [piaw_pkg::CodeW-1:0] code
  );
    logic [18:0] x;
    logic [6:0]  q0;
    logic [12:0] rem;
    x   = ({7'd0, code} << 6) + ({7'd0, code} << 5) + ({7'd0, code} << 2);
    q0  = x[18:12];
    rem = {1'b0, x[11:0]} + {6'd0, q0};
    code_to_pct = q0 + ((rem >= 13'd4095) ? 7'd1 : 7'd0);
  endfunction

  logic                          v1_q, v2_q, v3_q;
  logic                          rdy1, rdy2, rdy3;
  logic [piaw_pkg::CodeW-1:0]    tgt_q, meas_q;
  logic [piaw_pkg::PctW-1:0]     tgt_pct_q, meas_pct_q;
  logic signed [piaw_pkg::ErrW-1:0]   err_d, err_q;
  logic signed [piaw_pkg::IntegW-1:0] integ_d, integ_q;
  logic                          alarm_d, alarm_q;
  logic signed [12:0]            integ_sum, lim_s, integ_clamp;
  logic signed [piaw_pkg::ErrW-1:0]   err_abs;
  logic [piaw_pkg::LevelW-1:0]   err_mag;

  assign rdy3  = !v3_q || rdy_i;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign rdy_o = rdy1;

  assign err_d = $signed({1'b0, tgt_pct_q}) - $signed({1'b0, meas_pct_q});

  assign integ_sum = 13'(integ_q) + 13'(err_d);
  assign lim_s     = $signed({3'd0, cfg_i.windup_limit});

  always_comb begin
    priority if (integ_sum > lim_s) begin
      integ_clamp = lim_s;
    end else if (integ_sum < -lim_s) begin
      integ_clamp = -lim_s;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  assign integ_d = integ_clamp[piaw_pkg::IntegW-1:0];

  assign err_abs = err_d[piaw_pkg::ErrW-1] ? -err_d : err_d;
  assign err_mag = err_abs[piaw_pkg::LevelW-1:0];

  always_comb begin
    priority if (err_mag <= cfg_i.alarm_off_level) begin
      alarm_d = 1'b0;
    end else if (err_mag >= cfg_i.alarm_on_level) begin
      alarm_d = 1'b1;
    end else begin
      alarm_d = alarm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      integ_q <= '0;
      alarm_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= vld_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (v2_q && rdy3) begin
        integ_q <= integ_d;
        alarm_q <= alarm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && rdy1) begin
      tgt_q  <= target_code_i;
      meas_q <= measured_code_i;
    end
    if (v1_q && rdy2) begin
      tgt_pct_q  <= code_to_pct(tgt_q);
      meas_pct_q <= code_to_pct(meas_q);
    end
    if (v2_q && rdy3) begin
      err_q <= err_d;
    end
  end

  assign vld_o       = v3_q;
  assign res_o.err   = err_q;
  assign res_o.integ = integ_q;
  assign res_o.alarm = alarm_q;

endmodule

/* rtl/core/piaw_back.sv */
// Back pipeline: gain products, drive sum and clamp, duty mapping, result
// register. Depends on piaw_pkg.
`timescale 1ns / 1ps

module piaw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  piaw_pkg::cfg_t                cfg_i,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  piaw_pkg::front_res_t          res_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [piaw_pkg::DutyW-1:0]    duty_o,
  output logic [piaw_pkg::PctW-1:0]     drive_pct_o,
  output logic signed [piaw_pkg::ErrW-1:0] error_pct_o,
  output logic                          alarm_o
);

  logic                          v4_q, v5_q, v6_q;
  logic                          rdy4, rdy5, rdy6;
  logic signed [22:0]            prop_term_d, prop_term_q;
  logic signed [22:0]            integ_term_d, integ_term_q;
  logic signed [piaw_pkg::ErrW-1:0] err4_q, err5_q, err6_q;
  logic                          alarm4_q, alarm5_q, alarm6_q;
  logic signed [23:0]            drive_sum;
  logic [17:0]                   tenth_prod;
  logic [piaw_pkg::PctW-1:0]     drive_d, drive5_q, drive6_q;
  logic [16:0]                   duty_frac;
  logic [10:0]                   duty_full;
  logic [piaw_pkg::DutyW-1:0]    duty_d, duty_q;

  assign rdy6  = !v6_q || !out_stall_i;
  assign rdy5  = !v5_q || rdy6;
  assign rdy4  = !v4_q || rdy5;
  assign rdy_o = rdy4;

  assign prop_term_d  = 23'(res_i.err) * 23'($signed({1'b0, cfg_i.prop_gain}));
  assign integ_term_d = 23'(res_i.integ) * 23'($signed({1'b0, cfg_i.integ_gain}));

  // sum is in tenths; x*205>>11 equals x/10 for x below 1029
  assign drive_sum  = 24'(prop_term_q) + 24'(integ_term_q);
  assign tenth_prod = {8'd0, drive_sum[9:0]} * 18'd205;

  always_comb begin
    priority if (drive_sum < 24'sd0) begin
      drive_d = '0;
    end else if (drive_sum >= 24'sd1010) begin
      drive_d = 7'd100;
    end else begin
      drive_d = tenth_prod[17:11];
    end
  end

  // drive*1023/100 = drive*10 + drive*23/100, with drive*23*41>>12 exact up to 100
  assign duty_frac = {10'd0, drive5_q} * 17'd943;
  assign duty_full = ({4'd0, drive5_q} << 3) + ({4'd0, drive5_q} << 1)
                   + {6'd0, duty_frac[16:12]};
  assign duty_d    = duty_full[piaw_pkg::DutyW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= vld_i;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
      if (rdy6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i && rdy4) begin
      prop_term_q  <= prop_term_d;
      integ_term_q <= integ_term_d;
      err4_q       <= res_i.err;
      alarm4_q     <= res_i.alarm;
    end
    if (v4_q && rdy5) begin
      drive5_q <= drive_d;
      err5_q   <= err4_q;
      alarm5_q <= alarm4_q;
    end
    if (v5_q && rdy6) begin
      duty_q   <= duty_d;
      drive6_q <= drive5_q;
      err6_q   <= err5_q;
      alarm6_q <= alarm5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign duty_o      = duty_q;
  assign drive_pct_o = drive6_q;
  assign error_pct_o = err6_q;
  assign alarm_o     = alarm6_q;

endmodule

/* bench/tb_pi_controller_antiwindup_pwm.sv */
// Self-checking testbench for pi_controller_antiwindup_pwm: directed table, then random ticks.
// Results are checked against an in-bench predictor of the PI loop or pinned values; depends on piaw_pkg and the DUT.
`timescale 1ns / 1ps

module tb_pi_controller_antiwindup_pwm;
  import piaw_pkg::*;

  localparam int ItemsPerPhase = 150;
  localparam int NumPhases     = 11;
  localparam int SpareIdxLo    = 5;
  localparam int SpareIdxHi    = 2**CfgIdxW - 1;
  localparam int MaxCode       = 2**CodeW - 1;

  typedef struct packed {
    logic [DutyW-1:0]       duty;
    logic [PctW-1:0]        drive;
    logic signed [ErrW-1:0] err;
    logic                   alarm;
  } tick_result_t;

  typedef struct packed {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic [CodeW-1:0]    tgt;
    logic [CodeW-1:0]    meas;
    bit                  pinned;
    tick_result_t        res;
  } directed_row_t;

  typedef enum {StimUniform, StimNear, StimDrift} stim_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [CodeW-1:0]    target_code = '0;
  logic [CodeW-1:0]    measured_code = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [DutyW-1:0]    duty_o;
  logic [PctW-1:0]     drive_pct_o;
  logic signed [ErrW-1:0] error_pct_o;
  logic                alarm_o;

  bit                  pin_en = 1'b0;
  tick_result_t        pin_res = '0;

  int snd_idle = 0;
  int rcv_idle = 0;
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;

  cfg_t                   model_cfg;
  logic signed [IntegW-1:0] model_integ;
  logic                   model_alarm;
  tick_result_t           pending_ticks[$];
  directed_row_t          directed_rows[$];

  pi_controller_antiwindup_pwm DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .target_code_i   (target_code),
    .measured_code_i (measured_code),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .duty_o          (duty_o),
    .drive_pct_o     (drive_pct_o),
    .error_pct_o     (error_pct_o),
    .alarm_o         (alarm_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("tb_pi_controller_antiwindup_pwm: FAIL");
    $finish;
  end

  function automatic int code_to_pct(logic [CodeW-1:0] code);
    return (int'(code) * 100) / 4095;
  endfunction

  // Advance the loop state by one control tick and return its outputs.
  function automatic tick_result_t predict_tick(logic [CodeW-1:0] tgt, logic [CodeW-1:0] meas);
    tick_result_t res;
    int err;
    int acc;
    int lim;
    int sum;
    int drive;
    int mag;
    err = code_to_pct(tgt) - code_to_pct(meas);
    lim = int'(model_cfg.windup_limit);
    acc = int'(model_integ) + err;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    model_integ = IntegW'(acc);
    sum = err * int'(model_cfg.prop_gain) + acc * int'(model_cfg.integ_gain);
    if (sum < 0) drive = 0;
    else drive = (sum / 10 > 100) ? 100 : sum / 10;
    mag = (err < 0) ? -err : err;
    if (mag >= int'(model_cfg.alarm_on_level)) model_alarm = 1'b1;
    if (mag <= int'(model_cfg.alarm_off_level)) model_alarm = 1'b0;
    res.duty  = DutyW'((drive * 1023) / 100);
    res.drive = PctW'(drive);
    res.err   = ErrW'(err);
    res.alarm = model_alarm;
    return res;
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_n) begin : track
    tick_result_t want;
    if (!rst_n) begin
      model_cfg.prop_gain       = PropGainRst;
      model_cfg.integ_gain      = IntegGainRst;
      model_cfg.windup_limit    = WindupLimRst;
      model_cfg.alarm_on_level  = AlarmOnRst;
      model_cfg.alarm_off_level = AlarmOffRst;
      model_integ = '0;
      model_alarm = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          RegPropGain:  model_cfg.prop_gain       = cfg_data[PropW-1:0];
          RegIntegGain: model_cfg.integ_gain      = cfg_data[IgainW-1:0];
          RegWindupLim: model_cfg.windup_limit    = cfg_data[LimW-1:0];
          RegAlarmOn:   model_cfg.alarm_on_level  = cfg_data[LevelW-1:0];
          RegAlarmOff:  model_cfg.alarm_off_level = cfg_data[LevelW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall_o) begin
        want = predict_tick(target_code, measured_code);
        if (pin_en) want = pin_res;
        pending_ticks.push_back(want);
      end
      if (out_valid_o && !out_stall) begin
        if (pending_ticks.size() == 0) begin
          $display("%0t: result with no transfer pending: duty %0d drive %0d err %0d alarm %0d",
                   $time, duty_o, drive_pct_o, error_pct_o, alarm_o);
          mismatches++;
        end else begin
          want = pending_ticks.pop_front();
          check_field("duty", int'(want.duty), int'(duty_o));
          check_field("drive_pct", int'(want.drive), int'(drive_pct_o));
          check_field("error_pct", int'(want.err), int'(error_pct_o));
          check_field("alarm", int'(want.alarm), int'(alarm_o));
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  function automatic directed_row_t item_row(int tgt, int meas);
    directed_row_t row;
    row = '0;
    row.tgt  = CodeW'(tgt);
    row.meas = CodeW'(meas);
    return row;
  endfunction

  function automatic directed_row_t pinned_row(int tgt, int meas, int duty, int drive, int err,
                                               int alarm);
    directed_row_t row;
    row = item_row(tgt, meas);
    row.pinned    = 1'b1;
    row.res.duty  = DutyW'(duty);
    row.res.drive = PctW'(drive);
    row.res.err   = ErrW'(err);
    row.res.alarm = alarm[0];
    return row;
  endfunction

  function automatic directed_row_t cfg_row(logic [CfgIdxW-1:0] idx, int data);
    directed_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = CfgDataW'(data);
    return row;
  endfunction

  task automatic send_item(input logic [CodeW-1:0] tgt, input logic [CodeW-1:0] meas,
                           input bit pinned, input tick_result_t res);
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    target_code   <= tgt;
    measured_code <= meas;
    pin_en        <= pinned;
    pin_res       <= res;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CfgDataW'(data);
    @(posedge clk_i);
  endtask

  task automatic program_all(input int prop, input int igain, input int lim, input int lvl_on,
                             input int lvl_off);
    write_reg(RegPropGain, prop);
    write_reg(RegIntegGain, igain);
    write_reg(RegWindupLim, lim);
    write_reg(RegAlarmOn, lvl_on);
    write_reg(RegAlarmOff, lvl_off);
    write_reg(CfgIdxW'($urandom_range(SpareIdxLo, SpareIdxHi)), $urandom);
  endtask

  initial begin : stimulus
    int ph;
    int held_tgt;
    int held_off;
    int tgt;
    int meas;
    int pick;
    stim_kind_e kind;
    directed_row_t row;

    held_tgt = 2048;
    held_off = 0;
    snd_idle = 21;
    rcv_idle = 52;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: saturation both ways, negative drive, full drive
    directed_rows.push_back(pinned_row(0, 0, 0, 0, 0, 0));
    directed_rows.push_back(pinned_row(MaxCode, 0, 1023, 100, 100, 1));
    directed_rows.push_back(pinned_row(0, MaxCode, 0, 0, -100, 1));
    directed_rows.push_back(pinned_row(MaxCode, MaxCode, 0, 0, 0, 0));
    directed_rows.push_back(pinned_row(0, MaxCode, 0, 0, -100, 1));
    directed_rows.push_back(pinned_row(0, MaxCode, 0, 0, -100, 1));
    directed_rows.push_back(pinned_row(MaxCode, 0, 1023, 100, 100, 1));
    directed_rows.push_back(pinned_row(MaxCode, 0, 1023, 100, 100, 1));
    directed_rows.push_back(pinned_row(MaxCode, 0, 1023, 100, 100, 1));
    directed_rows.push_back(item_row(41, 40));
    directed_rows.push_back(item_row(40, 41));
    directed_rows.push_back(item_row(MaxCode - 1, 1));
    directed_rows.push_back(item_row(1, MaxCode - 1));
    directed_rows.push_back(item_row('hAAA, 'h555));
    directed_rows.push_back(item_row('h555, 'hAAA));
    directed_rows.push_back(item_row(2048, 1434));
    directed_rows.push_back(item_row(2048, 2048));
    directed_rows.push_back(item_row(2048, 1434));
    directed_rows.push_back(item_row(2048, 1229));
    directed_rows.push_back(item_row(2048, 1638));
    directed_rows.push_back(item_row(1434, 2048));
    // set level below clear level: clear must win
    directed_rows.push_back(cfg_row(RegAlarmOn, 5));
    directed_rows.push_back(cfg_row(RegAlarmOff, 50));
    directed_rows.push_back(item_row(2048, 819));
    directed_rows.push_back(item_row(3277, 819));
    directed_rows.push_back(item_row(2048, 819));
    // over-range limit, spare index ignored
    directed_rows.push_back(cfg_row(RegWindupLim, 'h3FFF));
    directed_rows.push_back(cfg_row(CfgIdxW'(SpareIdxLo + 1), 'h3FFF));
    directed_rows.push_back(item_row(MaxCode, 0));
    directed_rows.push_back(item_row(MaxCode, 0));
    directed_rows.push_back(item_row(MaxCode, 0));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        if (i == 0 || !directed_rows[i-1].is_cfg) wait_idle();
        write_reg(row.idx, int'(row.data));
      end else begin
        send_item(row.tgt, row.meas, row.pinned, row.res);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      if (ph < 4) begin
        snd_idle = 21;
        rcv_idle = 52;
      end else if (ph < 8) begin
        snd_idle = 52;
        rcv_idle = 21;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (ph)
        0: program_all(PropGainRst, IntegGainRst, WindupLimRst, AlarmOnRst, AlarmOffRst);
        1: program_all(9999, 999, 1000, 100, 100);
        2: program_all(0, 0, 0, 0, 0);
        3: program_all('h3FFF, 'h3FFF, 'h3FFF, 'h3FFF, 'h3FFF);
        4: program_all(140, 6, 100, 5, 50);
        default: program_all($urandom_range(0, 9999), $urandom_range(0, 999),
                             $urandom_range(0, 1000), $urandom_range(0, 100),
                             $urandom_range(0, 100));
      endcase
      repeat (ItemsPerPhase) begin
        pick = $urandom_range(0, 3);
        kind = (pick == 0) ? StimUniform : (pick == 1) ? StimNear : StimDrift;
        case (kind)
          StimUniform: begin
            tgt  = $urandom_range(0, MaxCode);
            meas = $urandom_range(0, MaxCode);
          end
          StimNear: begin
            tgt  = $urandom_range(0, MaxCode);
            meas = tgt + $urandom_range(0, 600) - 300;
          end
          default: begin
            if ($urandom_range(0, 29) == 0) begin
              held_tgt = $urandom_range(0, MaxCode);
              held_off = $urandom_range(0, 2400) - 1200;
            end
            tgt  = held_tgt;
            meas = held_tgt + held_off + $urandom_range(0, 40) - 20;
          end
        endcase
        if (meas < 0) meas = 0;
        if (meas > MaxCode) meas = MaxCode;
        send_item(CodeW'(tgt), CodeW'(meas), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && pending_ticks.size() == 0) begin
      $display("tb_pi_controller_antiwindup_pwm: PASS");
    end else begin
      $display("tb_pi_controller_antiwindup_pwm: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/piaw_pkg.sv
rtl/core/piaw_cfg.sv
rtl/core/piaw_front.sv
rtl/core/piaw_back.sv
rtl/core/pi_controller_antiwindup_pwm.sv
bench/tb_pi_controller_antiwindup_pwm.sv
